// ===== src/lph_pkg.sv =====
// Package with slot status codes, opcodes and the hash step for the linear probe table.
`default_nettype none
package lph_pkg;
  localparam int unsigned HashMult = 65599;
  // Number of slots; a power of two so that probe indexes wrap naturally.
  localparam int unsigned Capacity = 512;

  typedef enum logic [1:0] {
    OpInsert = 2'd0,
    OpLookup = 2'd1,
    OpRemove = 2'd2,
    OpClear  = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    StOk       = 2'd0,
    StNotFound = 2'd1,
    StFull     = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    SlotEmpty = 2'd0,
    SlotLive  = 2'd1,
    SlotTomb  = 2'd2
  } slot_e;

  // One step of the string hash: h * 65599 + byte, modulo 2^32.
  function automatic logic [31:0] hash_step(input logic [31:0] h, input logic [7:0] b);
    return h * 32'(HashMult) + {24'd0, b};
  endfunction
endpackage
`default_nettype wire

// ===== src/lph_hash.sv =====
// Sequential key hasher: normalizes the key and folds in one byte per cycle.
`default_nettype none
module lph_hash import lph_pkg::*; #(
  parameter int unsigned KeyBytes = 8
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [63:0] key_i,
  output logic        done_o,
  output logic [31:0] hash_o,
  output logic [63:0] key_o
);
  localparam int unsigned CntW = 4;

  logic            busy_q, busy_d;
  logic [CntW-1:0] idx_q, idx_d;
  logic [31:0]     h_q, h_d;
  logic [63:0]     raw_q, raw_d;
  logic [63:0]     k_q, k_d;
  logic            done_q, done_d;
  logic [7:0]      cur_b;

  assign cur_b = raw_q[8*idx_q[2:0] +: 8];

  always_comb begin
    busy_d = busy_q;
    idx_d  = idx_q;
    h_d    = h_q;
    raw_d  = raw_q;
    k_d    = k_q;
    done_d = 1'b0;
    if (start_i) begin
      busy_d = 1'b1;
      idx_d  = '0;
      h_d    = '0;
      raw_d  = key_i;
      k_d    = '0;
    end else if (busy_q) begin
      if (cur_b == 8'd0 || idx_q == CntW'(KeyBytes) || idx_q == CntW'(8)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end else begin
        h_d = hash_step(h_q, cur_b);
        k_d = k_q | (64'(cur_b) << (8 * idx_q[2:0]));
        idx_d = idx_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      idx_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      idx_q  <= idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    h_q   <= h_d;
    raw_q <= raw_d;
    k_q   <= k_d;
  end

  assign done_o = done_q;
  assign hash_o = h_q;
  assign key_o  = k_q;
endmodule
`default_nettype wire

// ===== src/linear_probe_hash_table.sv =====
// Top level of the linear probing key-value table with tombstones.
// Usage: requests enter on the s_axis group (op, key, value in tdata) and one
// response per request leaves on the m_axis group (status, value_res,
// live_count). The occupancy limit register is written through cfg_we_i.
// A request first runs through the byte-serial hasher (key bytes up to the
// first zero or KEY_BYTES), then a probe walk over the slot memory in which
// each slot visited is read from the synchronous memory and then inspected
// and written back. Lookup and remove visit at most live_count slots; insert
// visits up to that for the search and up to one more for the placement. A
// clear walks every slot, all Capacity (512) of them. One request is in
// flight at a time; the next is accepted once the response has moved into
// the output register, even while the receiver is stalling, as long as the
// output register is free again by completion. After reset a clearing pass
// writes every slot empty, during which s_axis_tready is low. When the
// receiver holds m_axis_tready low, the response waits in the output
// register and the block stalls before completing the next request.
`default_nettype none
module linear_probe_hash_table import lph_pkg::*; #(
  parameter int unsigned KEY_BYTES = 8
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         cfg_we_i,
  input  logic [8:0]   cfg_wdata_i,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [103:0] s_axis_tdata,  // op[1:0], key[65:2], value[97:66], zero fill
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [47:0]  m_axis_tdata   // status[1:0], value_res[33:2], live_count[43:34]
);
  localparam int unsigned AW = $clog2(Capacity);
  localparam int unsigned CW = AW + 1;

  typedef enum logic [6:0] {
    SInit  = 7'b0000001,
    SIdle  = 7'b0000010,
    SHash  = 7'b0000100,
    SRead  = 7'b0001000,
    SCheck = 7'b0010000,
    SClear = 7'b0100000,
    SDone  = 7'b1000000
  } state_e;

  logic [1:0]  slot_st_mem [Capacity];
  logic [63:0] slot_key_mem [Capacity];
  logic [31:0] slot_val_mem [Capacity];
  logic [1:0]  rd_st_q;
  logic [63:0] rd_key_q;
  logic [31:0] rd_val_q;

  state_e       state_q, state_d;
  logic [8:0]   limit_q;
  logic [CW-1:0] live_q, live_d, used_q, used_d;
  logic [AW-1:0] idx_q, idx_d;
  logic [CW-1:0] seen_q, seen_d;
  logic         place_q, place_d;   // second walk: placement phase of insert
  logic [1:0]   op_q;
  logic [63:0]  key_q;
  logic [31:0]  val_q;
  logic [1:0]   status_d;
  logic [31:0]  vres_d;
  logic [1:0]   res_st_q;
  logic [31:0]  res_v_q;
  logic         out_v_q;
  logic         finish;

  logic         we;
  logic [AW-1:0] waddr;
  logic [1:0]   wst;
  logic         wkv;

  logic         h_done;
  logic [31:0]  h_val;
  logic [63:0]  h_key;
  logic         accept;

  assign accept = s_axis_tvalid && s_axis_tready;
  assign s_axis_tready = (state_q == SIdle);

  lph_hash #(.KeyBytes(KEY_BYTES)) u_hash (
    .clk_i, .rst_ni,
    .start_i(accept), .key_i(s_axis_tdata[65:2]),
    .done_o(h_done), .hash_o(h_val), .key_o(h_key)
  );

  always_comb begin
    state_d  = state_q;
    live_d   = live_q;
    used_d   = used_q;
    idx_d    = idx_q;
    seen_d   = seen_q;
    place_d  = place_q;
    status_d = res_st_q;
    vres_d   = res_v_q;
    finish   = 1'b0;
    we       = 1'b0;
    waddr    = idx_q;
    wst      = SlotEmpty;
    wkv      = 1'b0;
    unique case (state_q)
      SInit: begin
        we = 1'b1;
        idx_d = idx_q + 1'b1;
        if (idx_q == AW'(Capacity - 1)) state_d = SIdle;
      end
      SIdle: if (accept) state_d = SHash;
      SHash: if (h_done) begin
        idx_d   = AW'(h_val % Capacity);
        seen_d  = '0;
        place_d = 1'b0;
        status_d = StOk;
        vres_d  = '0;
        if (op_q == OpClear) begin
          idx_d = '0;
          state_d = SClear;
        end else state_d = SRead;
      end
      SRead: begin
        if (!place_q && (seen_q >= live_q || seen_q >= CW'(Capacity))) begin
          // search missed
          if (op_q == OpInsert) begin
            if (used_q >= CW'(limit_q)) begin
              status_d = StFull;
              state_d = SDone;
            end else begin
              place_d = 1'b1;
              seen_d = '0;
              idx_d = AW'(h_val % Capacity);
            end
          end else begin
            status_d = StNotFound;
            state_d = SDone;
          end
        end else if (place_q && seen_q >= CW'(Capacity)) begin
          status_d = StFull;
          state_d = SDone;
        end else state_d = SCheck;
      end
      SCheck: begin
        state_d = SRead;
        seen_d = seen_q + 1'b1;
        idx_d = idx_q + 1'b1;
        if (place_q) begin
          if (rd_st_q != SlotLive) begin
            we = 1'b1; wst = SlotLive; wkv = 1'b1;
            if (rd_st_q == SlotEmpty) used_d = used_q + 1'b1;
            live_d = live_q + 1'b1;
            state_d = SDone;
          end
        end else if (rd_st_q == SlotEmpty) begin
          seen_d = live_q; idx_d = idx_q; // force the miss path
        end else if (rd_st_q == SlotLive && rd_key_q == key_q) begin
          state_d = SDone;
          if (op_q == OpInsert) begin
            we = 1'b1; wst = SlotLive; wkv = 1'b1;
          end else vres_d = rd_val_q;
          if (op_q == OpRemove) begin
            we = 1'b1; wst = SlotTomb;
            live_d = live_q - 1'b1;
          end
        end
      end
      SClear: begin
        we = 1'b1;
        idx_d = idx_q + 1'b1;
        if (idx_q == AW'(Capacity - 1)) begin
          live_d = '0; used_d = '0;
          state_d = SDone;
        end
      end
      SDone: if (!out_v_q || m_axis_tready) begin
        finish = 1'b1;
        state_d = SIdle;
      end
      default: state_d = SIdle;
    endcase
  end

  // Slot memories: one write and one registered read per cycle.
  always_ff @(posedge clk_i) begin
    if (we) begin
      slot_st_mem[waddr] <= wst;
      if (wkv) begin
        slot_key_mem[waddr] <= key_q;
        slot_val_mem[waddr] <= val_q;
      end
    end
    rd_st_q  <= slot_st_mem[idx_q];
    rd_key_q <= slot_key_mem[idx_q];
    rd_val_q <= slot_val_mem[idx_q];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= SInit;
      limit_q  <= 9'd358;
      live_q   <= '0;
      used_q   <= '0;
      idx_q    <= '0;
      seen_q   <= '0;
      place_q  <= 1'b0;
      out_v_q  <= 1'b0;
      res_st_q <= StOk;
      res_v_q  <= '0;
    end else begin
      state_q  <= state_d;
      live_q   <= live_d;
      used_q   <= used_d;
      idx_q    <= idx_d;
      seen_q   <= seen_d;
      place_q  <= place_d;
      res_st_q <= status_d;
      res_v_q  <= vres_d;
      if (cfg_we_i) limit_q <= cfg_wdata_i;
      if (finish) out_v_q <= 1'b1;
      else if (m_axis_tready) out_v_q <= 1'b0;
    end
  end

  logic [47:0] out_q;
  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q  <= s_axis_tdata[1:0];
      val_q <= s_axis_tdata[97:66];
    end
    if (h_done) key_q <= h_key;
    if (finish) out_q <= {4'd0, 10'(live_q), res_v_q, res_st_q};
  end

  assign m_axis_tvalid = out_v_q;
  assign m_axis_tdata  = out_q;
endmodule
`default_nettype wire

// ===== src/lph_checker.sv =====
// Port-level checker for the linear probe table, bound to the top level.
`default_nettype none
module lph_checker (
  input logic         clk_i,
  input logic         rst_ni,
  input logic         s_axis_tvalid,
  input logic         s_axis_tready,
  input logic         m_axis_tvalid,
  input logic         m_axis_tready,
  input logic [47:0]  m_axis_tdata
);
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("response dropped while stalled");
  a_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[1:0] != 2'd3)
    else $error("bad status code");
  a_live: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[43:34] <= 10'd512)
    else $error("live count beyond capacity");
  a_miss: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[1:0] != 2'd0 |-> m_axis_tdata[33:2] == 32'd0)
    else $error("nonzero value on failed request");
  a_one: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("two requests in flight");
endmodule

bind linear_probe_hash_table lph_checker u_lph_checker (
  .clk_i, .rst_ni, .s_axis_tvalid, .s_axis_tready,
  .m_axis_tvalid, .m_axis_tready, .m_axis_tdata
);
`default_nettype wire
